// ===== rtl/tec5_pkg.sv =====
// Shared constants, types and the texture mask for the 5x5 texture energy block.
package tec5_pkg;

    localparam int ENERGY_BITS    = 25;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 16;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int OUT_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int WIN            = 5;
    localparam int LINES          = 4;
    localparam int LINE_SEL_BITS  = 2;
    localparam int MIN_DIM        = 5;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Access to the line store: one read of all four lines and one write per item.
    typedef struct packed {
        logic                     en;
        logic [LINE_SEL_BITS-1:0] slot;
    } lb_ctl_t;

    localparam logic signed [7:0] MASK [WIN][WIN] = '{
        '{ 8'sd1,   -8'sd3,  -8'sd1,   -8'sd5,   8'sd0  },
        '{ -8'sd3,  8'sd4,   -8'sd38,  -8'sd4,   -8'sd7 },
        '{ -8'sd1,  -8'sd38, 8'sd100,  -8'sd10,  8'sd13 },
        '{ -8'sd5,  -8'sd4,  -8'sd10,  8'sd4,    -8'sd1 },
        '{ 8'sd0,   -8'sd7,  8'sd13,   -8'sd1,   8'sd3  }
    };

endpackage

// ===== rtl/tec5_line_buf.sv =====
// Four line memories, read together and written one line at a time at the same column.
module tec5_line_buf
    import tec5_pkg::*;
#(
    parameter int DEPTH      = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                             clk,
    input  lb_ctl_t                          ctl,
    input  logic [ADDR_BITS-1:0]             addr,
    input  logic [PIXEL_BITS-1:0]            wr_data,
    output logic [LINES-1:0][PIXEL_BITS-1:0] rd_data
);

    genvar b;
    generate
        for (b = 0; b < LINES; b++)
        begin : g_bank
            logic [PIXEL_BITS-1:0] mem [DEPTH];
            logic [PIXEL_BITS-1:0] q_reg;

            // Read-before-write: the read returns the line's old pixel at this column.
            always_ff @(posedge clk)
            begin
                if (ctl.en)
                begin
                    q_reg <= mem[addr];
                    if (ctl.slot == LINE_SEL_BITS'(b))
                    begin
                        mem[addr] <= wr_data;
                    end
                end
            end

            assign rd_data[b] = q_reg;
        end
    endgenerate

endmodule

// ===== rtl/texture_energy_conv5x5.sv =====
// Top level of the 5x5 texture energy convolution on a raster pixel stream.
// The block takes one pixel per clock unless the output stalls, and gives one result per
// fully covered 5x5 window, (height-4) x (width-4) results per frame, each tagged to the
// window's top-left pixel, with tlast on the last result of a row and tuser on the last
// result of the frame. A result is presented on m_tvalid after its pixel has passed four
// registers: line store read, window shift, row sums, total. The line store is four
// memories of MAX_WIDTH pixels, all read and one written per item at the current column,
// which sets the rate at one item per cycle unless the output stalls. The line store is
// not cleared; the first four rows of a frame fill it before any result uses it. Width
// and height must be written over the APB port only while idle, unchecked by the block.
module texture_energy_conv5x5
    import tec5_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int IN_DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,  // [PIXEL_BITS-1:0] pixel_value
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,  // [24:0] energy
    output logic                     m_tlast,  // row_end
    output logic                     m_tuser   // frame_end
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int CMP_BITS = (COL_BITS + 1 > WIDTH_BITS) ? COL_BITS + 1 : WIDTH_BITS;
    localparam logic [CMP_BITS-1:0]    MAX_W     = CMP_BITS'(MAX_WIDTH);
    localparam logic [CMP_BITS-1:0]    MIN_W     = CMP_BITS'(MIN_DIM);
    localparam logic [HEIGHT_BITS-1:0] MIN_H     = HEIGHT_BITS'(MIN_DIM);
    localparam logic [COL_BITS-1:0]    COL_FIRST = COL_BITS'(WIN - 1);
    localparam logic [HEIGHT_BITS-1:0] ROW_FIRST = HEIGHT_BITS'(WIN - 1);

    // Configuration registers
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic                   cfg_wr;

    // Position counters
    logic [COL_BITS-1:0]    col_reg, col_next, col_use;
    logic [HEIGHT_BITS-1:0] row_reg, row_next, row_use;
    logic [CMP_BITS-1:0]    w_eff, w_last, w_raw;
    logic [HEIGHT_BITS-1:0] h_eff, h_last;
    logic                   last_col, last_row, produce;

    // Pipeline handshake
    logic rdy1, rdy2, rdy3, rdy4, accept;

    // Stage 1: line store read in flight
    logic                     v1_reg;
    logic signed [PIXEL_BITS-1:0] px1_reg;
    logic [LINE_SEL_BITS-1:0] slot1_reg;
    logic                     prod1_reg, rend1_reg, fend1_reg;

    // Stage 2: window holds the item's neighborhood
    logic                     v2_reg, prod2_reg, rend2_reg, fend2_reg;
    logic signed [PIXEL_BITS-1:0] win_reg [WIN][WIN];

    // Stage 3: row sums
    logic                     v3_reg, rend3_reg, fend3_reg;
    logic signed [ENERGY_BITS-1:0] row_sum [WIN];
    logic signed [ENERGY_BITS-1:0] row_sum_reg [WIN];
    logic signed [ENERGY_BITS-1:0] total;

    // Output register
    logic                     ov_reg, rend_reg, fend_reg;
    logic signed [ENERGY_BITS-1:0] energy_reg;

    lb_ctl_t                          lb_ctl;
    logic [LINES-1:0][PIXEL_BITS-1:0] lb_rd;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_reg_t'(paddr[2]))
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_reg_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign rdy4     = !ov_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    // ---------------- position ----------------
    // Counts beyond a newly written width or height close that column or row at once.
    always_comb
    begin
        w_raw = CMP_BITS'(width_reg);
        if (w_raw < MIN_W)
        begin
            w_eff = MIN_W;
        end
        else if (w_raw > MAX_W)
        begin
            w_eff = MAX_W;
        end
        else
        begin
            w_eff = w_raw;
        end
        w_last   = w_eff - CMP_BITS'(1);
        col_use  = (CMP_BITS'(col_reg) >= w_eff) ? w_last[COL_BITS-1:0] : col_reg;
        last_col = (CMP_BITS'(col_use) == w_last);

        h_eff    = (height_reg < MIN_H) ? MIN_H : height_reg;
        h_last   = h_eff - HEIGHT_BITS'(1);
        row_use  = (row_reg >= h_eff) ? h_last : row_reg;
        last_row = (row_use == h_last);

        produce  = (row_use >= ROW_FIRST) && (col_use >= COL_FIRST);

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_use + HEIGHT_BITS'(1);
        end
        else
        begin
            col_next = col_use + COL_BITS'(1);
            row_next = row_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line store ----------------
    assign lb_ctl.en   = accept;
    assign lb_ctl.slot = row_use[LINE_SEL_BITS-1:0];

    tec5_line_buf #(
        .DEPTH      (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_line_buf (
        .clk     (clk),
        .ctl     (lb_ctl),
        .addr    (col_use),
        .wr_data (s_tdata[PIXEL_BITS-1:0]),
        .rd_data (lb_rd)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px1_reg   <= signed'(s_tdata[PIXEL_BITS-1:0]);
            slot1_reg <= row_use[LINE_SEL_BITS-1:0];
            prod1_reg <= produce;
            rend1_reg <= last_col;
            fend1_reg <= last_col && last_row;
        end
    end

    // ---------------- stage 2: window shift ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            for (int i = 0; i < WIN; i++)
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else if (rdy2)
        begin
            v2_reg <= v1_reg;
            if (v1_reg)
            begin
                for (int i = 0; i < WIN; i++)
                begin
                    for (int j = 0; j < WIN - 1; j++)
                    begin
                        win_reg[i][j] <= win_reg[i][j+1];
                    end
                end
                // The line at slot+i holds row r-4+i; the slot itself is the oldest row.
                for (int i = 0; i < LINES; i++)
                begin
                    win_reg[i][WIN-1] <=
                        signed'(lb_rd[slot1_reg + LINE_SEL_BITS'(i)]);
                end
                win_reg[WIN-1][WIN-1] <= px1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            prod2_reg <= prod1_reg;
            rend2_reg <= rend1_reg;
            fend2_reg <= fend1_reg;
        end
    end

    // ---------------- stage 3: row sums ----------------
    always_comb
    begin
        logic signed [ENERGY_BITS-1:0] acc;
        for (int i = 0; i < WIN; i++)
        begin
            acc = '0;
            for (int j = 0; j < WIN; j++)
            begin
                acc = acc + ENERGY_BITS'(ENERGY_BITS'(win_reg[i][j])
                                         * ENERGY_BITS'(MASK[i][j]));
            end
            row_sum[i] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            v3_reg <= v2_reg && prod2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            row_sum_reg <= row_sum;
            rend3_reg   <= rend2_reg;
            fend3_reg   <= fend2_reg;
        end
    end

    // ---------------- output stage ----------------
    always_comb
    begin
        total = '0;
        for (int i = 0; i < WIN; i++)
        begin
            total = total + row_sum_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (rdy4)
        begin
            ov_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            energy_reg <= total;
            rend_reg   <= rend3_reg;
            fend_reg   <= fend3_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = OUT_DATA_BITS'(unsigned'(energy_reg));
    assign m_tlast  = rend_reg;
    assign m_tuser  = fend_reg;

endmodule

// ===== rtl/tec5_checker.sv =====
// Port-level assertions for the texture energy block and the bind that attaches them.
module tec5_checker
    import tec5_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata,
    input logic                     m_tlast,
    input logic                     m_tuser
);

    // The last result of a frame also closes its row.
    a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("frame end without row end");

    // With the output free, every stage can move, so the input must be ready.
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output side is free");

    // The bits above the energy field are zero fill.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_BITS-1:ENERGY_BITS] == '0))
        else $error("nonzero padding in output item");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled output item changed");

endmodule

bind texture_energy_conv5x5 tec5_checker u_tec5_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
